>>> hdl/hph_pkg.sv
// Shared types and constants for the hexagon point hit test.
package hph_pkg;

  localparam int REG_BITS      = 11;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;
  localparam int K_BITS        = 2 * REG_BITS;
  localparam int NUM_VERT      = 6;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIDE_LEN   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_WIDTH = 2'd1;

  localparam logic [REG_BITS-1:0] SIDE_LEN_RESET   = 11'd64;
  localparam logic [REG_BITS-1:0] HALF_WIDTH_RESET = 11'd55;

  // Edges whose endpoint cross product is 2*h*(s/2) instead of h*s.
  localparam logic [NUM_VERT-1:0] EDGE_DOUBLE = 6'b010010;

  typedef struct packed {
    logic [REG_BITS-1:0] side_len;
    logic [REG_BITS-1:0] half_width;
  } hph_cfg_t;

endpackage

>>> hdl/hph_box_stage.sv
// First pipeline stage: captures the point and runs the bounding-box check.
module hph_box_stage #(
  parameter int COORD_BITS = 13
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic signed [COORD_BITS-1:0]  px,
  input  logic signed [COORD_BITS-1:0]  py,
  input  hph_pkg::hph_cfg_t             cfg,
  output logic signed [COORD_BITS-1:0]  x,
  output logic signed [COORD_BITS-1:0]  y,
  output logic                          box_ok
);

  localparam int BW = (COORD_BITS > hph_pkg::REG_BITS) ? COORD_BITS : hph_pkg::REG_BITS;

  logic [COORD_BITS-1:0] ax;
  logic [COORD_BITS-1:0] ay;
  logic                  box_ok_next;

  // The magnitude of the most negative value still fits as an unsigned number.
  assign ax = px[COORD_BITS-1] ? COORD_BITS'(~px + 1'b1) : px;
  assign ay = py[COORD_BITS-1] ? COORD_BITS'(~py + 1'b1) : py;

  assign box_ok_next = (BW'(ax) < BW'(cfg.half_width)) && (BW'(ay) < BW'(cfg.side_len));

  always_ff @(posedge clk) begin
    if (load) begin
      x      <= px;
      y      <= py;
      box_ok <= box_ok_next;
    end
  end

endmodule

>>> hdl/hph_mul_stage.sv
// Second pipeline stage: the products that every vertex cross product is built from.
module hph_mul_stage #(
  parameter int COORD_BITS = 13,
  localparam int PW = COORD_BITS + 12
) (
  input  logic                             clk,
  input  logic                             load,
  input  logic signed [COORD_BITS-1:0]     x,
  input  logic signed [COORD_BITS-1:0]     y,
  input  logic                             box_in,
  input  hph_pkg::hph_cfg_t                cfg,
  output logic signed [PW-1:0]             xs,
  output logic signed [PW-1:0]             xhs,
  output logic signed [PW-1:0]             yh,
  output logic [hph_pkg::K_BITS-1:0]       ks,
  output logic [hph_pkg::K_BITS-1:0]       khs2,
  output logic                             box_out
);

  logic signed [hph_pkg::REG_BITS:0] s12;
  logic signed [hph_pkg::REG_BITS:0] hs12;
  logic signed [hph_pkg::REG_BITS:0] h12;
  logic [hph_pkg::K_BITS-2:0]        khs;

  assign s12  = signed'({1'b0, cfg.side_len});
  assign hs12 = signed'({2'b00, cfg.side_len[hph_pkg::REG_BITS-1:1]});
  assign h12  = signed'({1'b0, cfg.half_width});

  assign khs = (hph_pkg::K_BITS-1)'(cfg.half_width) *
               (hph_pkg::K_BITS-1)'(cfg.side_len[hph_pkg::REG_BITS-1:1]);

  always_ff @(posedge clk) begin
    if (load) begin
      xs      <= PW'(x) * PW'(s12);
      xhs     <= PW'(x) * PW'(hs12);
      yh      <= PW'(y) * PW'(h12);
      ks      <= hph_pkg::K_BITS'(cfg.half_width) * hph_pkg::K_BITS'(cfg.side_len);
      khs2    <= {khs, 1'b0};
      box_out <= box_in;
    end
  end

endmodule

>>> hdl/hph_cross_stage.sv
// Third pipeline stage: cross product of the point with each of the six vertices.
module hph_cross_stage #(
  parameter int COORD_BITS = 13,
  localparam int PW = COORD_BITS + 12,
  localparam int CW = PW + 1
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic signed [PW-1:0]        xs,
  input  logic signed [PW-1:0]        xhs,
  input  logic signed [PW-1:0]        yh,
  input  logic [hph_pkg::K_BITS-1:0]  ks_in,
  input  logic [hph_pkg::K_BITS-1:0]  khs2_in,
  input  logic                        box_in,
  output logic signed [CW-1:0]        vc [hph_pkg::NUM_VERT],
  output logic [hph_pkg::K_BITS-1:0]  ks,
  output logic [hph_pkg::K_BITS-1:0]  khs2,
  output logic                        box_out
);

  logic signed [CW-1:0] exs;
  logic signed [CW-1:0] exhs;
  logic signed [CW-1:0] eyh;

  assign exs  = CW'(xs);
  assign exhs = CW'(xhs);
  assign eyh  = CW'(yh);

  // Vertices in order: (0,-s), (-h,-s/2), (-h,s/2), (0,s), (h,s/2), (h,-s/2).
  always_ff @(posedge clk) begin
    if (load) begin
      vc[0]   <= -exs;
      vc[1]   <= eyh - exhs;
      vc[2]   <= eyh + exhs;
      vc[3]   <= exs;
      vc[4]   <= exhs - eyh;
      vc[5]   <= -exhs - eyh;
      ks      <= ks_in;
      khs2    <= khs2_in;
      box_out <= box_in;
    end
  end

endmodule

>>> hdl/hph_edge_stage.sv
// Last pipeline stage: segment-against-edge sign tests and the registered result.
module hph_edge_stage #(
  parameter int COORD_BITS = 13,
  localparam int CW = COORD_BITS + 13,
  localparam int EW = COORD_BITS + 16
) (
  input  logic                        clk,
  input  logic                        load,
  input  logic signed [CW-1:0]        vc [hph_pkg::NUM_VERT],
  input  logic [hph_pkg::K_BITS-1:0]  ks,
  input  logic [hph_pkg::K_BITS-1:0]  khs2,
  input  logic                        box_ok,
  output logic                        inside_res
);

  logic [hph_pkg::NUM_VERT-1:0] hit;

  // For edge A->B with K = -(A x B): the origin side is K > 0, the point side
  // is the sign of (P x A) - (P x B) - K, and the edge ends lie on either side
  // of the segment when P x A and P x B differ in sign.
  for (genvar gi = 0; gi < hph_pkg::NUM_VERT; gi++) begin : g_edge
    localparam int NX = (gi + 1) % hph_pkg::NUM_VERT;

    logic [hph_pkg::K_BITS-1:0] k;
    logic signed [EW-1:0]       pv;
    logic                       c11;
    logic                       c12;

    assign k   = hph_pkg::EDGE_DOUBLE[gi] ? khs2 : ks;
    assign pv  = EW'(vc[gi]) - EW'(vc[NX]) - EW'(signed'({1'b0, k}));
    assign c11 = |k;
    assign c12 = pv[EW-1];
    assign hit[gi] = (c11 != c12) && (vc[gi][CW-1] != vc[NX][CW-1]);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      inside_res <= box_ok && !(|hit);
    end
  end

endmodule

>>> hdl/hexagon_point_hit_test.sv
// Top level of the pointy-top hexagon point hit test.
//
// Each word (px, py) is a point relative to the hexagon centre and gives one
// word inside_res, high when the point lies strictly inside. The block takes
// one word per cycle while item_stall is low. The stages are the bounding-box
// check, the coordinate products, the six vertex cross products and the edge
// sign tests with the output register. A stall on the result side fills empty
// stages first before it reaches item_stall.
// Configuration writes are taken in every cycle (cfg_ready is always high) and
// must be made while no point is in flight.
module hexagon_point_hit_test #(
  parameter int COORD_BITS = 13
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  logic signed [COORD_BITS-1:0]       px,
  input  logic signed [COORD_BITS-1:0]       py,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic                               inside_res,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hph_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [hph_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int PW = COORD_BITS + 12;
  localparam int CW = PW + 1;

  hph_pkg::hph_cfg_t cfg;

  logic v1, v2, v3, v4;
  logic ready1, ready2, ready3, ready4;

  logic signed [COORD_BITS-1:0] x1, y1;
  logic                         box1, box2, box3;
  logic signed [PW-1:0]         xs2, xhs2, yh2;
  logic [hph_pkg::K_BITS-1:0]   ks2, khs22, ks3, khs23;
  logic signed [CW-1:0]         vc3 [hph_pkg::NUM_VERT];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.side_len   <= hph_pkg::SIDE_LEN_RESET;
      cfg.half_width <= hph_pkg::HALF_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hph_pkg::CFG_SIDE_LEN:   cfg.side_len   <= cfg_data[hph_pkg::REG_BITS-1:0];
        hph_pkg::CFG_HALF_WIDTH: cfg.half_width <= cfg_data[hph_pkg::REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its contents move on in the same cycle.
  assign ready4 = !v4 || !res_stall;
  assign ready3 = !v3 || ready4;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;

  assign item_stall = !ready1;
  assign res_valid  = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (ready1) begin
        v1 <= item_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (ready4) begin
        v4 <= v3;
      end
    end
  end

  hph_box_stage #(.COORD_BITS(COORD_BITS)) u_box (
    .clk    (clk),
    .load   (ready1),
    .px     (px),
    .py     (py),
    .cfg    (cfg),
    .x      (x1),
    .y      (y1),
    .box_ok (box1)
  );

  hph_mul_stage #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk     (clk),
    .load    (ready2),
    .x       (x1),
    .y       (y1),
    .box_in  (box1),
    .cfg     (cfg),
    .xs      (xs2),
    .xhs     (xhs2),
    .yh      (yh2),
    .ks      (ks2),
    .khs2    (khs22),
    .box_out (box2)
  );

  hph_cross_stage #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk     (clk),
    .load    (ready3),
    .xs      (xs2),
    .xhs     (xhs2),
    .yh      (yh2),
    .ks_in   (ks2),
    .khs2_in (khs22),
    .box_in  (box2),
    .vc      (vc3),
    .ks      (ks3),
    .khs2    (khs23),
    .box_out (box3)
  );

  hph_edge_stage #(.COORD_BITS(COORD_BITS)) u_edge (
    .clk        (clk),
    .load       (ready4),
    .vc         (vc3),
    .ks         (ks3),
    .khs2       (khs23),
    .box_ok     (box3),
    .inside_res (inside_res)
  );

  // A point rejected by the bounding box must never come out as inside.
  a_box_reject: assert property (@(posedge clk) disable iff (rst)
    (ready4 && v3 && !box3) |=> (res_valid && !inside_res))
    else $error("bounding-box reject reported as inside");

  // A word leaving the first stage must land in the second.
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (ready2 && v1) |=> v2)
    else $error("word lost between first and second stage");

  // Without a stall on the result side the input is never held off.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !res_stall |-> !item_stall)
    else $error("input stalled while the result side is free");

endmodule

>>> tb/hexagon_point_hit_test_checker.sv
`timescale 1ns / 100ps
// Checker for the hexagon point hit test: predicts inside_res for every word and compares.
module hexagon_point_hit_test_checker #(
  parameter int COORD_BITS = 13
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  input  logic                                item_stall,
  input  logic signed [COORD_BITS-1:0]        px,
  input  logic signed [COORD_BITS-1:0]        py,
  input  logic                                res_valid,
  input  logic                                res_stall,
  input  logic                                inside_res,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [hph_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [hph_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output int                                  failures,
  output int                                  outstanding
);

  typedef struct {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    bit                           hit;
  } hit_answer_t;

  hit_answer_t expected_hits[$];
  logic [hph_pkg::REG_BITS-1:0] side_cfg;
  logic [hph_pkg::REG_BITS-1:0] half_cfg;

  function automatic longint cross2(longint ux, longint uy, longint vx, longint vy);
    return ux * vy - vx * uy;
  endfunction

  // A side a->b blocks the ray from the centre to p only on strict sign changes.
  function automatic bit side_blocks(longint ax, longint ay, longint bx, longint by,
                                     longint qx, longint qy);
    longint ex;
    longint ey;
    bit     c11;
    bit     c12;
    bit     c21;
    bit     c22;
    ex  = bx - ax;
    ey  = by - ay;
    c11 = cross2(ex, ey, -ax, -ay) < 0;
    c12 = cross2(ex, ey, qx - ax, qy - ay) < 0;
    c21 = cross2(qx, qy, ax, ay) < 0;
    c22 = cross2(qx, qy, bx, by) < 0;
    return (c11 != c12) && (c21 != c22);
  endfunction

  function automatic bit hex_contains(logic signed [COORD_BITS-1:0] x_in,
                                      logic signed [COORD_BITS-1:0] y_in,
                                      logic [hph_pkg::REG_BITS-1:0] side,
                                      logic [hph_pkg::REG_BITS-1:0] half);
    longint x;
    longint y;
    longint s;
    longint h;
    longint hs;
    longint vx[hph_pkg::NUM_VERT];
    longint vy[hph_pkg::NUM_VERT];
    x  = x_in;
    y  = y_in;
    s  = side;
    h  = half;
    hs = s / 2;
    if ((x < 0 ? -x : x) >= h || (y < 0 ? -y : y) >= s) return 1'b0;
    vx[0] = 0;  vy[0] = -s;
    vx[1] = -h; vy[1] = -hs;
    vx[2] = -h; vy[2] = hs;
    vx[3] = 0;  vy[3] = s;
    vx[4] = h;  vy[4] = hs;
    vx[5] = h;  vy[5] = -hs;
    for (int i = 0; i < hph_pkg::NUM_VERT; i++) begin
      if (side_blocks(vx[i], vy[i], vx[(i + 1) % hph_pkg::NUM_VERT],
                      vy[(i + 1) % hph_pkg::NUM_VERT], x, y))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    failures = failures + 1;
  endtask

  always @(posedge clk) begin
    hit_answer_t due;
    hit_answer_t fresh;
    if (rst) begin
      expected_hits.delete();
      side_cfg = hph_pkg::SIDE_LEN_RESET;
      half_cfg = hph_pkg::HALF_WIDTH_RESET;
      failures = 0;
      outstanding <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_hits.size() == 0) begin
          report_mismatch($sformatf("result word %0b with no point outstanding", inside_res));
        end else begin
          due = expected_hits.pop_front();
          if (inside_res !== due.hit)
            report_mismatch($sformatf("point (%0d,%0d): inside_res %0b, want %0b",
                                      due.x, due.y, inside_res, due.hit));
        end
      end
      if (item_valid && !item_stall) begin
        fresh.x   = px;
        fresh.y   = py;
        fresh.hit = hex_contains(px, py, side_cfg, half_cfg);
        expected_hits.push_back(fresh);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          hph_pkg::CFG_SIDE_LEN: begin
            side_cfg = cfg_data[hph_pkg::REG_BITS-1:0];
          end
          hph_pkg::CFG_HALF_WIDTH: begin
            half_cfg = cfg_data[hph_pkg::REG_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
      outstanding <= expected_hits.size();
    end
  end

endmodule

>>> tb/hexagon_point_hit_test_tb.sv
`timescale 1ns / 100ps
// Testbench top for the hexagon point hit test: clock, reset, stimulus and verdict.
module hexagon_point_hit_test_tb;

  localparam int COORD_BITS     = 13;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLDOFF_CYCLES = 60;
  localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));

  // Indexes that the block does not decode; writes to them must be ignored.
  localparam logic [hph_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [hph_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_EVERY_THIRD
  } stall_mode_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                item_valid;
  logic                                item_stall;
  logic signed [COORD_BITS-1:0]        px;
  logic signed [COORD_BITS-1:0]        py;
  logic                                res_valid;
  logic                                res_stall = 1'b0;
  logic                                inside_res;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [hph_pkg::CFG_IDX_BITS-1:0]    cfg_index;
  logic [hph_pkg::CFG_DATA_BITS-1:0]   cfg_data;

  int failures;
  int outstanding;
  int cycle_count = 0;

  logic             holdoff_req;
  logic             holdoff_used;
  int               holdoff_left;
  stall_mode_t      stall_mode;
  int               mode_left;
  logic [1:0]       third_tick;

  logic [hph_pkg::REG_BITS-1:0] side_now;
  logic [hph_pkg::REG_BITS-1:0] half_now;
  int                           burst_left;

  hexagon_point_hit_test #(.COORD_BITS(COORD_BITS)) uut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .px         (px),
    .py         (py),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .inside_res (inside_res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  hexagon_point_hit_test_checker #(.COORD_BITS(COORD_BITS)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .px          (px),
    .py          (py),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .inside_res  (inside_res),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result-side back-pressure: random segments of different stall patterns, plus
  // one long hold-off on request so the pipeline fills and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      res_stall    <= 1'b0;
      holdoff_used <= 1'b0;
      holdoff_left <= 0;
      stall_mode   <= STALL_NONE;
      mode_left    <= 0;
      third_tick   <= 2'd0;
    end else if (holdoff_left != 0) begin
      res_stall    <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_req && !holdoff_used && item_valid) begin
      res_stall    <= 1'b1;
      holdoff_used <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES;
    end else begin
      third_tick <= (third_tick == 2'd2) ? 2'd0 : third_tick + 2'd1;
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(10, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE: begin
          res_stall <= 1'b0;
        end
        STALL_LIGHT: begin
          res_stall <= ($urandom_range(0, 3) == 0);
        end
        STALL_HEAVY: begin
          res_stall <= ($urandom_range(0, 9) < 7);
        end
        default: begin
          res_stall <= (third_tick != 2'd0);
        end
      endcase
    end
  end

  function automatic logic signed [COORD_BITS-1:0] to_coord(int v);
    if (v > COORD_MAX) return COORD_BITS'(COORD_MAX);
    if (v < COORD_MIN) return COORD_BITS'(COORD_MIN);
    return COORD_BITS'(v);
  endfunction

  function automatic int legit_half(int s);
    return $rtoi(s * 0.8660254037844386 + 0.5);
  endfunction

  // Offers one word and returns once it is accepted; valid is lowered only when a
  // gap follows, so back-to-back words keep it high.
  task automatic send_point(int x, int y, bit steady);
    int gap;
    item_valid <= 1'b1;
    px         <= to_coord(x);
    py         <= to_coord(y);
    @(posedge clk);
    while (item_stall) @(posedge clk);
    burst_left = burst_left - 1;
    if (burst_left <= 0 && !steady) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 5);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Mostly points around the hexagon, some at or near a vertex, some anywhere.
  task automatic run_points(int count, int steady_count);
    int wx;
    int wy;
    int pick;
    int rx;
    int ry;
    int hs;
    int vert;
    for (int n = 0; n < count; n++) begin
      wx   = int'(half_now) + 3;
      wy   = int'(side_now) + 3;
      hs   = int'(side_now) / 2;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        rx = int'($urandom_range(0, 2 * wx)) - wx;
        ry = int'($urandom_range(0, 2 * wy)) - wy;
      end else if (pick < 17) begin
        vert = $urandom_range(0, hph_pkg::NUM_VERT - 1);
        case (vert)
          0: begin rx = 0;               ry = -int'(side_now); end
          1: begin rx = -int'(half_now); ry = -hs;             end
          2: begin rx = -int'(half_now); ry = hs;              end
          3: begin rx = 0;               ry = int'(side_now);  end
          4: begin rx = int'(half_now);  ry = hs;              end
          default: begin rx = int'(half_now); ry = -hs;        end
        endcase
        rx = rx + int'($urandom_range(0, 6)) - 3;
        ry = ry + int'($urandom_range(0, 6)) - 3;
      end else begin
        rx = int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
        ry = int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
      end
      send_point(rx, ry, n < steady_count);
    end
    item_valid <= 1'b0;
  endtask

  // The outstanding count is registered in the checker, so look only after the next edge.
  task automatic wait_idle();
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic cfg_write(logic [hph_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [hph_pkg::CFG_DATA_BITS-1:0] word);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic run_phase(logic [hph_pkg::CFG_DATA_BITS-1:0] side_word,
                           logic [hph_pkg::CFG_DATA_BITS-1:0] half_word,
                           int count, int steady_count);
    wait_idle();
    cfg_write(hph_pkg::CFG_SIDE_LEN, side_word);
    cfg_write(hph_pkg::CFG_HALF_WIDTH, half_word);
    if ($urandom_range(0, 1))
      cfg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 16'($urandom));
    cfg_valid <= 1'b0;
    side_now = side_word[hph_pkg::REG_BITS-1:0];
    half_now = half_word[hph_pkg::REG_BITS-1:0];
    @(posedge clk);
    run_points(count, steady_count);
  endtask

  initial begin
    int s;
    rst         <= 1'b1;
    item_valid  <= 1'b0;
    px          <= '0;
    py          <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= hph_pkg::CFG_SIDE_LEN;
    cfg_data    <= '0;
    holdoff_req <= 1'b0;
    side_now    = hph_pkg::SIDE_LEN_RESET;
    half_now    = hph_pkg::HALF_WIDTH_RESET;
    burst_left  = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry: side 64, half-width 55, s/2 = 32.
    send_point(0, 0, 1'b0);
    send_point(COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MIN, 1'b0);
    send_point(COORD_MIN, 0, 1'b0);
    send_point(0, COORD_MAX, 1'b0);
    send_point(54, 0, 1'b0);
    send_point(55, 0, 1'b0);
    send_point(-55, 0, 1'b0);
    send_point(0, 63, 1'b0);
    send_point(0, 64, 1'b0);
    send_point(0, -64, 1'b0);
    send_point(0, -63, 1'b0);
    send_point(54, 31, 1'b0);
    send_point(54, 32, 1'b0);
    send_point(54, 33, 1'b0);
    send_point(-54, -33, 1'b0);
    send_point(27, 48, 1'b0);
    send_point(27, 49, 1'b0);
    send_point(-27, -48, 1'b0);
    send_point(-27, -49, 1'b0);
    send_point(1, 63, 1'b0);
    send_point(-1, -63, 1'b0);
    item_valid <= 1'b0;

    run_phase(16'd2, 16'd1, 40, 0);
    run_phase(16'd2047, 16'd1773, 70, 0);
    s = $urandom_range(2, 40);
    run_phase(16'(s), 16'(legit_half(s)), 65, 0);
    s = $urandom_range(40, 400);
    run_phase(16'(s), 16'(legit_half(s)), 65, 0);
    s = $urandom_range(2, 2047);
    run_phase(16'(s), 16'(legit_half(s)), 65, 0);
    // Zero registers with junk in the unused upper data bits.
    run_phase({5'($urandom), 11'd0}, {5'($urandom), 11'd0}, 20, 0);
    run_phase(16'd2047, 16'd2047, 40, 0);
    run_phase(16'($urandom), 16'($urandom), 60, 0);
    s = $urandom_range(2, 2047);
    run_phase(16'(s), 16'(legit_half(s)), 65, 0);
    // The hold-off starts once this phase offers words, so the pipeline backs up.
    holdoff_req <= 1'b1;
    run_phase({5'h1f, hph_pkg::SIDE_LEN_RESET}, {5'h15, hph_pkg::HALF_WIDTH_RESET}, 135, 45);

    wait_idle();
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/hph_pkg.sv
hdl/hph_box_stage.sv
hdl/hph_mul_stage.sv
hdl/hph_cross_stage.sv
hdl/hph_edge_stage.sv
hdl/hexagon_point_hit_test.sv
tb/hexagon_point_hit_test_checker.sv
tb/hexagon_point_hit_test_tb.sv
